### src/psb_pkg.sv
package psb_pkg;

    // buffer geometry
    localparam int SLOTS       = 128;
    localparam int PACKET_BITS = 64;

    // port widths fixed by the interface
    localparam int DATA_W  = 64;
    localparam int LIMIT_W = 7;

    // derived widths
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);

    localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RESET = LIMIT_W'(7);

    // item kinds
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_STORE   = 4'b0010,
        ST_FETCH   = 4'b0100,
        ST_DELIVER = 4'b1000
    } psb_state_t;

endpackage

### src/packet_slot_buffer_core.sv
// channel   | handshake                 | payload
// ----------+---------------------------+-------------------------------
// in        | in_valid / in_stall       | kind, packet_in
// out       | out_valid / out_stall     | status, packet_out
// cfg       | cfg_valid / cfg_ready     | cfg_data (probe_limit)
//
// an item is taken only in idle; one slot probe per cycle through the shared
// pointer incrementer and the occupancy bitmap select
// store: accept, then probes from 1 to probe_limit+1, then deliver
// fetch: accept, then probes from 1 to SLOTS, then deliver; empty fails without a probe
// reset clears bitmap, count, pointers and sets probe_limit to 7; no sweep
// a stalled result sits in the output register while the next item is taken
module packet_slot_buffer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // input transfers
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [psb_pkg::DATA_W-1:0]    packet_in,
    // result transfers
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic [psb_pkg::DATA_W-1:0]    packet_out,
    // configuration transfers
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [psb_pkg::LIMIT_W-1:0]   cfg_data
);
    import psb_pkg::*;

    // control state
    psb_state_t              state_reg, state_next;
    logic [SLOTS-1:0]        occ_reg, occ_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [SLOT_W-1:0]       wp_reg, wp_next;
    logic [SLOT_W-1:0]       rp_reg, rp_next;
    logic [LIMIT_W-1:0]      limit_reg, limit_next;
    logic [LIMIT_W-1:0]      attempt_reg, attempt_next;
    logic                    out_valid_reg, out_valid_next;

    // payload / result holding
    logic [PACKET_BITS-1:0]  pkt_reg, pkt_next;
    logic                    res_fail_reg, res_fail_next;
    logic                    res_fetch_reg, res_fetch_next;
    logic                    status_reg, status_next;
    logic [DATA_W-1:0]       pkt_out_reg, pkt_out_next;

    // packet memory
    logic [PACKET_BITS-1:0]  mem [SLOTS];
    logic [PACKET_BITS-1:0]  rd_data_reg;
    logic                    mem_we;
    logic                    mem_re;

    // shared probe unit: one slot pointer, its successor and its occupancy
    logic [SLOT_W-1:0]       probe_slot;
    logic [SLOT_W-1:0]       probe_succ;
    logic                    probe_busy;
    logic                    out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign packet_out = pkt_out_reg;

    assign out_free   = !out_valid_reg || !out_stall;
    assign probe_slot = (state_reg == ST_FETCH) ? rp_reg : wp_reg;
    assign probe_succ = (probe_slot == SLOT_W'(SLOTS - 1)) ? '0 : probe_slot + 1'b1;
    assign probe_busy = occ_reg[probe_slot];

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        count_next     = count_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        limit_next     = limit_reg;
        attempt_next   = attempt_reg;
        out_valid_next = out_valid_reg;
        pkt_next       = pkt_reg;
        res_fail_next  = res_fail_reg;
        res_fetch_next = res_fetch_reg;
        status_next    = status_reg;
        pkt_out_next   = pkt_out_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        // result register drains on a transfer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pkt_next       = packet_in[PACKET_BITS-1:0];
                    attempt_next   = '0;
                    res_fetch_next = (kind == KIND_FETCH);
                    state_next     = (kind == KIND_FETCH) ? ST_FETCH : ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (!probe_busy)
                begin
                    // free slot: take it
                    mem_we               = 1'b1;
                    occ_next[probe_slot] = 1'b1;
                    count_next           = count_reg + 1'b1;
                    wp_next              = probe_succ;
                    res_fail_next        = 1'b0;
                    state_next           = ST_DELIVER;
                end
                else if (attempt_reg >= limit_reg)
                begin
                    // out of probes, pointer stays on the last busy slot
                    res_fail_next = 1'b1;
                    state_next    = ST_DELIVER;
                end
                else
                begin
                    wp_next      = probe_succ;
                    attempt_next = attempt_reg + 1'b1;
                end
            end
            ST_FETCH:
            begin
                if (count_reg == '0)
                begin
                    res_fail_next = 1'b1;
                    state_next    = ST_DELIVER;
                end
                else
                begin
                    rp_next = probe_succ;
                    if (probe_busy)
                    begin
                        mem_re               = 1'b1;
                        occ_next[probe_slot] = 1'b0;
                        count_next           = count_reg - 1'b1;
                        res_fail_next        = 1'b0;
                        state_next           = ST_DELIVER;
                    end
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_fail_reg ? STATUS_FAIL : STATUS_OK;
                    pkt_out_next   = (res_fetch_reg && !res_fail_reg)
                                   ? DATA_W'(rd_data_reg) : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            count_reg     <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            limit_reg     <= PROBE_LIMIT_RESET;
            attempt_reg   <= '0;
            out_valid_reg <= 1'b0;
            res_fail_reg  <= 1'b0;
            res_fetch_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            count_reg     <= count_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            limit_reg     <= limit_next;
            attempt_reg   <= attempt_next;
            out_valid_reg <= out_valid_next;
            res_fail_reg  <= res_fail_next;
            res_fetch_reg <= res_fetch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg     <= pkt_next;
        status_reg  <= status_next;
        pkt_out_reg <= pkt_out_next;
    end

    // single port packet memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[probe_slot] <= pkt_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[probe_slot];
        end
    end

    // count tracks the bitmap
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == COUNT_W'($countones(occ_reg)))
        else $error("occupancy count out of step with bitmap");

    // a new result only comes out of the deliver step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && out_stall)) |->
            $past(state_reg == ST_DELIVER))
        else $error("result loaded outside deliver step");

    // a fetch on an empty buffer fails without probing
    a_empty_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH && count_reg == '0) |=>
            (state_reg == ST_DELIVER && res_fail_reg))
        else $error("empty fetch did not fail at once");

    // an accepted item starts a probe sequence
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_STORE || state_reg == ST_FETCH))
        else $error("accepted item did not start probing");

endmodule
